// File: hdl/rufd_pkg.sv
// Package: shared types and constants for the radar serial deframer.
package rufd_pkg;

  // Result kind codes
  localparam logic [1:0] KIND_TARGET  = 2'd0;
  localparam logic [1:0] KIND_END     = 2'd1;
  localparam logic [1:0] KIND_STATUS  = 2'd2;
  localparam logic [1:0] KIND_PAYLOAD = 2'd3;

  // Configuration register indexes
  localparam logic CFG_WAIT_ENABLE  = 1'b0;
  localparam logic CFG_EXPECTED     = 1'b1;

  localparam logic [15:0] ACK_REPLY_BIT = 16'h0100;
  localparam logic [15:0] NO_STATUS     = 16'hFFFF;
  localparam logic [15:0] SAT_POS       = 16'h7FFF;
  localparam logic [15:0] SAT_NEG       = 16'h8000;
  localparam int          TGT_FRAME_LEN = 30;
  localparam int          ACK_OVERHEAD  = 10;

  // Header and tail bytes
  localparam logic [7:0] TGT_H0 = 8'hAA, TGT_H1 = 8'hFF, TGT_H2 = 8'h03, TGT_H3 = 8'h00;
  localparam logic [7:0] TGT_T0 = 8'h55, TGT_T1 = 8'hCC;
  localparam logic [7:0] ACK_H0 = 8'hFD, ACK_H1 = 8'hFC, ACK_H2 = 8'hFB, ACK_H3 = 8'hFA;
  localparam logic [7:0] ACK_T0 = 8'h04, ACK_T1 = 8'h03, ACK_T2 = 8'h02, ACK_T3 = 8'h01;

  // Result payload
  typedef struct packed {
    logic [1:0]  result_kind;
    logic signed [15:0] target_x_mm;
    logic signed [15:0] target_y_mm;
    logic signed [15:0] target_speed_mm_s;
    logic [15:0] target_resolution_mm;
    logic [1:0]  target_count;
    logic [15:0] ack_status;
    logic [4:0]  payload_length;
    logic [7:0]  payload_byte;
    logic        last;
  } result_t;

  // Controller states
  typedef enum logic [4:0] {
    ST_IDLE,      // wait for a byte
    ST_APPEND,    // unused; leads on to the scan
    ST_SCAN,      // look for a header at the scan position
    ST_SCAN_RD,   // wait for read data
    ST_HDR_DONE,  // evaluate header match
    ST_FRAME,     // frame header at front: read field bytes
    ST_FRAME_RD,
    ST_ACK_LEN,
    ST_ACK_TAIL,
    ST_ACK_WORD,
    ST_ACK_STAT,
    ST_ACK_EMIT,
    ST_ACK_PAY,
    ST_TGT_TAIL,
    ST_TGT_SLOT,
    ST_TGT_EMIT,
    ST_TGT_END,
    ST_DROP,      // shift the window front by drop count
    ST_OUT,       // hold a result until taken
    ST_FLUSH      // set last flag on the final result
  } state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic        append;      // write the input byte at the fill position
    logic        rd;          // read window at rd_addr (relative to front)
    logic [7:0]  rd_addr;
    logic        cap;         // capture read data into byte slot cap_sel
    logic [3:0]  cap_sel;
    logic        drop;        // advance the front by drop_n
    logic [7:0]  drop_n;
    logic        keep3;       // drop all but the last three bytes
  } dp_cmd_t;

  typedef struct packed {
    logic [8:0]  fill;
    logic [7:0]  rd_data;
  } dp_stat_t;

  // Decode sign-magnitude word
  function automatic logic signed [15:0] sign_mag(input logic [15:0] raw);
    logic signed [15:0] mag;
    mag = {1'b0, raw[14:0]};
    return raw[15] ? mag : -mag;
  endfunction

  // Speed times ten with saturation
  function automatic logic signed [15:0] speed_x10(input logic [15:0] raw);
    logic signed [19:0] v;
    v = (20'(signed'(sign_mag(raw))) <<< 3) + (20'(signed'(sign_mag(raw))) <<< 1);
    if (v > 20'sd32767) return SAT_POS;
    if (v < -20'sd32768) return SAT_NEG;
    return v[15:0];
  endfunction

endpackage

// File: hdl/rufd_stream_if.sv
// Interface: valid/ready channel carrying a generic payload.
interface rufd_stream_if #(
  parameter int W = 8
);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: hdl/rufd_window.sv
// Datapath: circular byte window with one read port and a fill count.
module rufd_window #(
  parameter int WINDOW_DEPTH = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  rufd_pkg::dp_cmd_t   cmd,
  input  logic [7:0]          in_byte,
  output rufd_pkg::dp_stat_t  stat
);
  import rufd_pkg::*;

  localparam int AW = $clog2(WINDOW_DEPTH);

  logic [7:0]  mem [WINDOW_DEPTH];
  logic [AW-1:0] head;
  logic [8:0]  fill;
  logic [7:0]  rd_data;

  function automatic logic [AW-1:0] wrap(input logic [8:0] a);
    logic [9:0] s;
    s = 10'(head) + 10'(a);
    if (s >= 10'(WINDOW_DEPTH)) s = s - 10'(WINDOW_DEPTH);
    return s[AW-1:0];
  endfunction

  // Write the incoming byte; a full window first loses its oldest byte
  always_ff @(posedge clk) begin
    if (cmd.append) begin
      if (fill == 9'(WINDOW_DEPTH)) mem[head] <= in_byte;
      else mem[wrap(fill)] <= in_byte;
    end
    if (cmd.rd) rd_data <= mem[wrap({1'b0, cmd.rd_addr})];
  end

  // Track front pointer and count
  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      fill <= '0;
    end else if (cmd.append) begin
      if (fill == 9'(WINDOW_DEPTH)) head <= wrap(9'd1);
      else fill <= fill + 9'd1;
    end else if (cmd.keep3) begin
      if (fill >= 9'd3) begin
        head <= wrap(fill - 9'd3);
        fill <= 9'd3;
      end
    end else if (cmd.drop) begin
      if (9'(cmd.drop_n) >= fill) begin
        head <= wrap(fill);
        fill <= '0;
      end else begin
        head <= wrap(9'(cmd.drop_n));
        fill <= fill - 9'(cmd.drop_n);
      end
    end
  end

  assign stat.fill    = fill;
  assign stat.rd_data = rd_data;

  // The count never exceeds the depth
  assert property (@(posedge clk) disable iff (rst) fill <= 9'(WINDOW_DEPTH))
    else $error("window overfilled");
  // An append never leaves the window empty
  assert property (@(posedge clk) disable iff (rst) cmd.append |=> fill != 0)
    else $error("append lost");
  // keep3 leaves at most three bytes
  assert property (@(posedge clk) disable iff (rst) cmd.keep3 && !cmd.append |=> fill <= 9'd3)
    else $error("keep3 failed");
endmodule

// File: hdl/rufd_ctrl.sv
// Controller: scans the window, parses frames and sequences results.
module rufd_ctrl #(
  parameter int MAX_ACK_LENGTH = 32,
  parameter int MAX_PAYLOAD    = 26,
  parameter int TARGET_SLOTS   = 3
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  output rufd_pkg::dp_cmd_t   cmd,
  input  rufd_pkg::dp_stat_t  stat,
  input  logic                wait_en,
  input  logic [15:0]         expected,
  output logic                out_valid,
  input  logic                out_ready,
  output rufd_pkg::result_t   out_res
);
  import rufd_pkg::*;

  state_t      state, state_next;
  logic [7:0]  pos, pos_next;        // scan or field index
  logic [7:0]  idx, idx_next;        // byte index within frame step
  logic [7:0]  b [4];                // captured field bytes
  logic [7:0]  alen, alen_next;
  logic [15:0] status, status_next;
  logic [4:0]  extra, extra_next;
  logic [1:0]  slot, slot_next;
  logic [1:0]  active, active_next;
  logic [5:0]  emitted, emitted_next;
  logic        is_ack, is_ack_next;
  logic [3:0]  hmatch_t, hmatch_a, hmatch_t_next, hmatch_a_next;
  logic [1:0]  k, k_next;            // byte counter inside a group
  logic        have, have_next;      // a result is held for output
  result_t     pend, pend_next;      // result being built
  result_t     out_hold, out_hold_next; // held result (last set at flush)
  state_t      ret, ret_next;        // state after an output handshake

  logic [7:0]  rd;
  assign rd = stat.rd_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      have    <= 1'b0;
      emitted <= '0;
    end else begin
      state   <= state_next;
      have    <= have_next;
      emitted <= emitted_next;
    end
    pos <= pos_next; idx <= idx_next; alen <= alen_next; status <= status_next;
    extra <= extra_next; slot <= slot_next; active <= active_next;
    is_ack <= is_ack_next; k <= k_next;
    hmatch_t <= hmatch_t_next; hmatch_a <= hmatch_a_next;
    pend <= pend_next; out_hold <= out_hold_next; ret <= ret_next;
    if (cmd.cap) b[cmd.cap_sel[1:0]] <= rd;
  end

  logic [15:0] w01, w23;
  assign w01 = {b[1], b[0]};
  assign w23 = {b[3], b[2]};

  // Next state and commands
  always_comb begin
    state_next = state; pos_next = pos; idx_next = idx; alen_next = alen;
    status_next = status; extra_next = extra; slot_next = slot;
    active_next = active; emitted_next = emitted; is_ack_next = is_ack;
    k_next = k; hmatch_t_next = hmatch_t; hmatch_a_next = hmatch_a;
    have_next = have; pend_next = pend; out_hold_next = out_hold; ret_next = ret;
    cmd = '0;
    in_ready = 1'b0;
    out_valid = 1'b0;
    out_res = out_hold;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.append = 1'b1;
          emitted_next = '0;
          have_next = 1'b0;
          state_next = ST_SCAN;
          pos_next = '0;
        end
      end
      ST_APPEND: state_next = ST_SCAN;
      // Header search at pos: read four bytes
      ST_SCAN: begin
        if (9'(pos) + 9'd4 > stat.fill) begin
          cmd.keep3 = 1'b1;
          state_next = ST_FLUSH;
        end else begin
          cmd.rd = 1'b1; cmd.rd_addr = pos;
          k_next = '0; hmatch_t_next = '0; hmatch_a_next = '0;
          state_next = ST_SCAN_RD;
        end
      end
      ST_SCAN_RD: begin
        unique case (k)
          2'd0: begin hmatch_t_next[0] = rd == TGT_H0; hmatch_a_next[0] = rd == ACK_H0; end
          2'd1: begin hmatch_t_next[1] = rd == TGT_H1; hmatch_a_next[1] = rd == ACK_H1; end
          2'd2: begin hmatch_t_next[2] = rd == TGT_H2; hmatch_a_next[2] = rd == ACK_H2; end
          default: begin hmatch_t_next[3] = rd == TGT_H3; hmatch_a_next[3] = rd == ACK_H3; end
        endcase
        if (k == 2'd3) state_next = ST_HDR_DONE;
        else begin
          k_next = k + 2'd1;
          cmd.rd = 1'b1; cmd.rd_addr = pos + 8'(k) + 8'd1;
        end
      end
      ST_HDR_DONE: begin
        if (&hmatch_t || &hmatch_a) begin
          is_ack_next = !(&hmatch_t);
          cmd.drop = pos != 0; cmd.drop_n = pos;
          state_next = ST_FRAME;
        end else begin
          pos_next = pos + 8'd1;
          state_next = ST_SCAN;
        end
      end
      // Header at front: check length
      ST_FRAME: begin
        if (is_ack) begin
          if (stat.fill < 9'd6) state_next = ST_FLUSH;
          else begin
            cmd.rd = 1'b1; cmd.rd_addr = 8'd4; k_next = '0;
            state_next = ST_ACK_LEN;
          end
        end else begin
          if (stat.fill < 9'(TGT_FRAME_LEN)) state_next = ST_FLUSH;
          else begin
            cmd.rd = 1'b1; cmd.rd_addr = 8'd28; k_next = '0;
            state_next = ST_TGT_TAIL;
          end
        end
      end
      ST_ACK_LEN: begin
        cmd.cap = 1'b1; cmd.cap_sel = 4'(k);
        if (k == 2'd0) begin
          k_next = 2'd1; cmd.rd = 1'b1; cmd.rd_addr = 8'd5;
        end else if ({rd, b[0]} > 16'(MAX_ACK_LENGTH)) begin
          cmd.drop = 1'b1; cmd.drop_n = 8'd1; pos_next = '0;
          state_next = ST_SCAN;
        end else begin
          alen_next = b[0];
          if (9'(b[0]) + 9'(ACK_OVERHEAD) > stat.fill) state_next = ST_FLUSH;
          else begin
            k_next = '0; cmd.rd = 1'b1; cmd.rd_addr = b[0] + 8'd6;
            state_next = ST_ACK_TAIL;
          end
        end
      end
      ST_ACK_TAIL: begin
        if ((k == 2'd0 && rd != ACK_T0) || (k == 2'd1 && rd != ACK_T1) ||
            (k == 2'd2 && rd != ACK_T2) || (k == 2'd3 && rd != ACK_T3)) begin
          cmd.drop = 1'b1; cmd.drop_n = 8'd1; pos_next = '0;
          state_next = ST_SCAN;
        end else if (k != 2'd3) begin
          k_next = k + 2'd1; cmd.rd = 1'b1; cmd.rd_addr = alen + 8'd7 + 8'(k);
        end else if (alen >= 8'd2 && wait_en) begin
          k_next = '0; cmd.rd = 1'b1; cmd.rd_addr = 8'd6;
          state_next = ST_ACK_WORD;
        end else state_next = ST_DROP;
      end
      // Command word then status, bytes 6..9
      ST_ACK_WORD: begin
        cmd.cap = 1'b1; cmd.cap_sel = 4'(k);
        k_next = k + 2'd1;
        if (k != 2'd3) begin cmd.rd = 1'b1; cmd.rd_addr = 8'd7 + 8'(k); end
        else state_next = ST_ACK_STAT;
      end
      ST_ACK_STAT: begin
        if (w01 != (expected | ACK_REPLY_BIT)) state_next = ST_DROP;
        else begin
          status_next = (alen >= 8'd4) ? w23 : NO_STATUS;
          if (alen > 8'd4)
            extra_next = (alen - 8'd4 > 8'(MAX_PAYLOAD)) ? 5'(MAX_PAYLOAD) : 5'(alen - 8'd4);
          else extra_next = '0;
          state_next = ST_ACK_EMIT;
        end
      end
      ST_ACK_EMIT: begin
        pend_next = '0;
        pend_next.result_kind = KIND_STATUS;
        pend_next.ack_status = status;
        pend_next.payload_length = extra;
        idx_next = '0;
        ret_next = ST_ACK_PAY;
        state_next = ST_OUT;
      end
      ST_ACK_PAY: begin
        if (idx == 8'(extra)) state_next = ST_DROP;
        else begin
          cmd.rd = 1'b1; cmd.rd_addr = 8'd10 + idx;
          state_next = ST_FRAME_RD;
        end
      end
      ST_FRAME_RD: begin
        pend_next = '0;
        pend_next.result_kind = KIND_PAYLOAD;
        pend_next.ack_status = status;
        pend_next.payload_length = extra;
        pend_next.payload_byte = rd;
        idx_next = idx + 8'd1;
        ret_next = ST_ACK_PAY;
        state_next = ST_OUT;
      end
      ST_TGT_TAIL: begin
        if (k == 2'd0) begin
          if (rd != TGT_T0) begin
            cmd.drop = 1'b1; cmd.drop_n = 8'd1; pos_next = '0; state_next = ST_SCAN;
          end else begin k_next = 2'd1; cmd.rd = 1'b1; cmd.rd_addr = 8'd29; end
        end else if (rd != TGT_T1) begin
          cmd.drop = 1'b1; cmd.drop_n = 8'd1; pos_next = '0; state_next = ST_SCAN;
        end else begin
          slot_next = '0; active_next = '0; k_next = '0; idx_next = '0;
          cmd.rd = 1'b1; cmd.rd_addr = 8'd4;
          state_next = ST_TGT_SLOT;
        end
      end
      // Read eight slot bytes: x,y first (0..3), then speed,res (4..7)
      ST_TGT_SLOT: begin
        cmd.cap = 1'b1; cmd.cap_sel = 4'(k);
        idx_next = idx + 8'd1;
        k_next = k + 2'd1;
        if (idx[1:0] == 2'd3) begin
          if (idx == 8'd3) begin
            pend_next = '0;
            pend_next.result_kind = KIND_TARGET;
            pend_next.target_x_mm = sign_mag({b[1], b[0]});
            pend_next.target_y_mm = sign_mag({b[3], rd});
            // b[3] not yet captured: finish in next state
          end
          state_next = ST_TGT_EMIT;
        end else begin
          cmd.rd = 1'b1; cmd.rd_addr = 8'd4 + {slot, 3'b0} + idx + 8'd1;
        end
      end
      ST_TGT_EMIT: begin
        if (idx == 8'd4) begin
          pend_next.target_y_mm = sign_mag(w23);
          cmd.rd = 1'b1; cmd.rd_addr = 8'd4 + {slot, 3'b0} + 8'd4;
          state_next = ST_TGT_SLOT;
        end else begin
          pend_next.target_speed_mm_s = speed_x10(w01);
          pend_next.target_resolution_mm = w23;
          slot_next = slot + 2'd1;
          idx_next = '0;
          if (pend.target_x_mm != 0 || pend.target_y_mm != 0) begin
            active_next = active + 2'd1;
            ret_next = ST_TGT_END;
            state_next = ST_OUT;
          end else state_next = ST_TGT_END;
        end
      end
      ST_TGT_END: begin
        if (slot != 2'(TARGET_SLOTS)) begin
          cmd.rd = 1'b1; cmd.rd_addr = 8'd4 + {slot, 3'b0};
          state_next = ST_TGT_SLOT;
        end else begin
          pend_next = '0;
          pend_next.result_kind = KIND_END;
          pend_next.target_count = active;
          idx_next = 8'(ACK_OVERHEAD - 10 + TGT_FRAME_LEN) - 8'(ACK_OVERHEAD) - 8'd10;
          alen_next = 8'(TGT_FRAME_LEN - ACK_OVERHEAD);
          ret_next = ST_DROP;
          state_next = ST_OUT;
        end
      end
      ST_DROP: begin
        cmd.drop = 1'b1;
        cmd.drop_n = is_ack ? alen + 8'(ACK_OVERHEAD) : 8'(TGT_FRAME_LEN);
        pos_next = '0;
        state_next = ST_SCAN;
      end
      // Stage a result; the previously held one goes out first
      ST_OUT: begin
        if (emitted == 6'd48) state_next = ret;
        else if (!have) begin
          have_next = 1'b1; out_hold_next = pend; emitted_next = emitted + 6'd1;
          state_next = ret;
        end else begin
          out_valid = 1'b1;
          out_res = out_hold;
          out_res.last = 1'b0;
          if (out_ready) begin
            out_hold_next = pend; emitted_next = emitted + 6'd1;
            state_next = ret;
          end
        end
      end
      ST_FLUSH: begin
        if (!have) state_next = ST_IDLE;
        else begin
          out_valid = 1'b1; out_res = out_hold; out_res.last = 1'b1;
          if (out_ready) begin have_next = 1'b0; state_next = ST_IDLE; end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Sequential controller: no new byte while results remain
  assert property (@(posedge clk) disable iff (rst) in_ready |-> !have)
    else $error("byte taken with result pending");
  assert property (@(posedge clk) disable iff (rst) emitted <= 6'd48)
    else $error("result overflow");
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_res.last |-> state == ST_FLUSH)
    else $error("last outside flush");
endmodule

// File: hdl/radar_uart_frame_deframer.sv
// Top level: radar serial deframer for target and command reply frames.
//
// Channels: rx (sink) carries one received byte per transfer; res (source)
// carries one result per transfer; a plain write port sets the two config
// registers (index 0 wait enable, index 1 expected command word).
// Each byte is appended to a circular window, then the controller rescans
// the window through its single read port, one window byte at a time.
// A byte that completes nothing has each scanned position read as four
// header bytes, and every dropped byte starts a new scan; a good target
// frame is then parsed slot by slot and its results go out in transfers.
// The next byte is taken only once the scan ends and all results of the
// current one are transferred.
// Results leave one at a time, one held back until the next is ready, so
// that last can mark the final result of a byte.
// A stalled receiver holds the controller with the result steady.
// Reset clears the window count, the registers and the controller; window
// contents are left as they are.
module radar_uart_frame_deframer #(
  parameter int WINDOW_DEPTH   = 64,
  parameter int MAX_ACK_LENGTH = 32,
  parameter int MAX_PAYLOAD    = 26,
  parameter int TARGET_SLOTS   = 3
) (
  input  logic        clk,
  input  logic        rst,
  rufd_stream_if.sink   rx,
  rufd_stream_if.source res,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);
  import rufd_pkg::*;

  dp_cmd_t     cmd;
  dp_stat_t    stat;
  logic        wait_en;
  logic [15:0] expected;
  result_t     r;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      wait_en  <= 1'b0;
      expected <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_WAIT_ENABLE: wait_en <= cfg_data[0];
        CFG_EXPECTED:    expected <= cfg_data;
        default: ;
      endcase
    end
  end

  rufd_window #(.WINDOW_DEPTH(WINDOW_DEPTH)) u_win (
    .clk(clk), .rst(rst), .cmd(cmd), .in_byte(rx.data), .stat(stat)
  );

  rufd_ctrl #(
    .MAX_ACK_LENGTH(MAX_ACK_LENGTH), .MAX_PAYLOAD(MAX_PAYLOAD),
    .TARGET_SLOTS(TARGET_SLOTS)
  ) u_ctrl (
    .clk(clk), .rst(rst), .in_valid(rx.valid), .in_ready(rx.ready),
    .cmd(cmd), .stat(stat), .wait_en(wait_en), .expected(expected),
    .out_valid(res.valid), .out_ready(res.ready), .out_res(r)
  );

  assign res.data = r;
endmodule
